@@ hdl/sha1mh_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1mh_pkg
// shared types and constants of the sha-1 message hasher
// ----------------------------------------------------------------------------
`default_nettype none

package sha1mh_pkg;

   // round constants, one per group of twenty rounds
   localparam logic [31:0] K_ROUND0 = 32'h5a827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
   localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;

   // initial chaining values
   localparam logic [31:0] HASH_INIT [5] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [6:0] ROUND_SCHED = 7'd16;
   localparam logic [6:0] ROUND_G1    = 7'd20;
   localparam logic [6:0] ROUND_G2    = 7'd40;
   localparam logic [6:0] ROUND_G3    = 7'd60;
   localparam logic [6:0] ROUND_LAST  = 7'd79;

   localparam logic [2:0] WORD_LAST = 3'd4;

   // source of the byte shifted into the block buffer
   typedef enum logic [1:0] {
      SEL_IN,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic         shift;      // shift one byte into the block buffer
      byte_sel_type sel;
      logic         count_inc;  // message byte, bump the length counter
      logic         load_len;   // latch the bit length for the trailer
      logic         start;      // load working variables from the hash
      logic         round;      // run one compression round
      logic [6:0]   round_idx;
      logic         fold;       // add working variables into the hash
      logic         clear;      // back to initial values for a new message
      logic [2:0]   word_idx;   // digest word on the result port
   } dp_cmd_type;

endpackage

`default_nettype wire

@@ hdl/sha1mh_dp.sv @@
// ----------------------------------------------------------------------------
// sha1mh_dp
// datapath: block buffer, message schedule, round logic and chaining values
// ----------------------------------------------------------------------------
`default_nettype none

module sha1mh_dp import sha1mh_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   input  wire logic [7:0]  req_byte,
   output logic [31:0]      digest_word
);

   // block buffer, word 0 in the top bits; bytes and schedule words shift in
   logic [511:0] blk_ff, blk_in;
   logic [63:0]  len_ff, len_in;
   logic [60:0]  count_ff, count_in;
   logic [31:0]  hash_ff [5];
   logic [31:0]  hash_in [5];
   logic [31:0]  var_ff [5];
   logic [31:0]  var_in [5];

   logic [7:0]   byte_val;
   logic [31:0]  w0, w2, w8, w13, w_x, w_val;
   logic [31:0]  f_val, k_val, t_val;

   always_comb begin
      case (cmd.sel)
         SEL_IN:   byte_val = req_byte;
         SEL_MARK: byte_val = PAD_MARK;
         SEL_ZERO: byte_val = 8'h00;
         SEL_LEN:  byte_val = len_ff[63:56];
         default:  byte_val = 8'h00;
      endcase
   end

   // schedule taps: w[t-16], w[t-14], w[t-8], w[t-3]
   assign w0    = blk_ff[511:480];
   assign w2    = blk_ff[447:416];
   assign w8    = blk_ff[255:224];
   assign w13   = blk_ff[95:64];
   assign w_x   = w13 ^ w8 ^ w2 ^ w0;
   assign w_val = (cmd.round_idx < ROUND_SCHED) ? w0 : {w_x[30:0], w_x[31]};

   always_comb begin
      if (cmd.round_idx < ROUND_G1) begin
         f_val = (var_ff[1] & var_ff[2]) | (~var_ff[1] & var_ff[3]);
         k_val = K_ROUND0;
      end else if (cmd.round_idx < ROUND_G2) begin
         f_val = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         k_val = K_ROUND1;
      end else if (cmd.round_idx < ROUND_G3) begin
         f_val = (var_ff[1] & var_ff[2]) | (var_ff[1] & var_ff[3])
               | (var_ff[2] & var_ff[3]);
         k_val = K_ROUND2;
      end else begin
         f_val = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         k_val = K_ROUND3;
      end
   end

   assign t_val = {var_ff[0][26:0], var_ff[0][31:27]} + f_val + var_ff[4] + k_val + w_val;

   always_comb begin
      blk_in   = blk_ff;
      len_in   = len_ff;
      count_in = count_ff;
      hash_in  = hash_ff;
      var_in   = var_ff;

      if (cmd.shift) begin
         blk_in = {blk_ff[503:0], byte_val};
      end else if (cmd.round) begin
         blk_in = {blk_ff[479:0], w_val};
      end

      if (cmd.load_len) begin
         len_in = {count_ff, 3'b000};
      end else if (cmd.shift && cmd.sel == SEL_LEN) begin
         len_in = {len_ff[55:0], 8'h00};
      end

      if (cmd.count_inc) begin
         count_in = count_ff + 61'd1;
      end

      if (cmd.start) begin
         var_in = hash_ff;
      end else if (cmd.round) begin
         var_in[0] = t_val;
         var_in[1] = var_ff[0];
         var_in[2] = {var_ff[1][1:0], var_ff[1][31:2]};
         var_in[3] = var_ff[2];
         var_in[4] = var_ff[3];
      end

      if (cmd.fold) begin
         for (int i = 0; i < 5; i++) begin
            hash_in[i] = hash_ff[i] + var_ff[i];
         end
      end

      if (cmd.clear) begin
         hash_in  = HASH_INIT;
         count_in = '0;
         for (int i = 0; i < 5; i++) begin
            var_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hash_ff  <= HASH_INIT;
         for (int i = 0; i < 5; i++) begin
            var_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         hash_ff  <= hash_in;
         var_ff   <= var_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      len_ff <= len_in;
   end

   always_comb begin
      case (cmd.word_idx)
         3'd0:    digest_word = hash_ff[0];
         3'd1:    digest_word = hash_ff[1];
         3'd2:    digest_word = hash_ff[2];
         3'd3:    digest_word = hash_ff[3];
         3'd4:    digest_word = hash_ff[4];
         default: digest_word = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/sha1mh_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha1mh_ctrl
// controller: byte position, padding sequence, round count and digest output
// ----------------------------------------------------------------------------
`default_nettype none

module sha1mh_ctrl import sha1mh_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_tvalid,
   input  wire logic   req_has_byte,
   input  wire logic   req_end,
   input  wire logic   rsp_tready,
   output logic        req_tready,
   output logic        rsp_tvalid,
   output logic [2:0]  word_index,
   output logic        last_word,
   output dp_cmd_type  cmd
);

   localparam logic [5:0] POS_LAST   = 6'd63;
   localparam logic [5:0] POS_PRELEN = 6'd55;
   localparam logic [2:0] LEN_LAST   = 3'd7;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROUND,
      S_FOLD,
      S_PADMARK,
      S_PADZERO,
      S_PADLEN,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RET_IDLE,
      RET_PADMARK,
      RET_PADZERO,
      RET_EMIT
   } ret_type;

   state_type  state_ff, state_in;
   ret_type    ret_ff, ret_in;
   logic [5:0] pos_ff, pos_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] lenb_ff, lenb_in;
   logic [2:0] word_ff, word_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign word_index = word_ff;
   assign last_word  = (word_ff == WORD_LAST);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      pos_in   = pos_ff;
      round_in = round_ff;
      lenb_in  = lenb_ff;
      word_in  = word_ff;
      cmd      = '0;
      cmd.sel       = SEL_IN;
      cmd.round_idx = round_ff;
      cmd.word_idx  = word_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_has_byte) begin
                  cmd.shift     = 1'b1;
                  cmd.count_inc = 1'b1;
                  pos_in        = pos_ff + 6'd1;
                  if (pos_ff == POS_LAST) begin
                     cmd.start = 1'b1;
                     round_in  = '0;
                     state_in  = S_ROUND;
                     ret_in    = req_end ? RET_PADMARK : RET_IDLE;
                  end else if (req_end) begin
                     state_in = S_PADMARK;
                  end
               end else if (req_end) begin
                  state_in = S_PADMARK;
               end
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            if (round_ff == ROUND_LAST) begin
               round_in = '0;
               state_in = S_FOLD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            case (ret_ff)
               RET_IDLE:    state_in = S_IDLE;
               RET_PADMARK: state_in = S_PADMARK;
               RET_PADZERO: state_in = S_PADZERO;
               RET_EMIT:    state_in = S_EMIT;
               default:     state_in = S_IDLE;
            endcase
         end
         S_PADMARK: begin
            cmd.shift    = 1'b1;
            cmd.sel      = SEL_MARK;
            cmd.load_len = 1'b1;
            pos_in       = pos_ff + 6'd1;
            if (pos_ff == POS_LAST) begin
               cmd.start = 1'b1;
               round_in  = '0;
               state_in  = S_ROUND;
               ret_in    = RET_PADZERO;
            end else if (pos_ff == POS_PRELEN) begin
               lenb_in  = '0;
               state_in = S_PADLEN;
            end else begin
               state_in = S_PADZERO;
            end
         end
         S_PADZERO: begin
            cmd.shift = 1'b1;
            cmd.sel   = SEL_ZERO;
            pos_in    = pos_ff + 6'd1;
            if (pos_ff == POS_LAST) begin
               cmd.start = 1'b1;
               round_in  = '0;
               state_in  = S_ROUND;
               ret_in    = RET_PADZERO;
            end else if (pos_ff == POS_PRELEN) begin
               lenb_in  = '0;
               state_in = S_PADLEN;
            end
         end
         S_PADLEN: begin
            cmd.shift = 1'b1;
            cmd.sel   = SEL_LEN;
            pos_in    = pos_ff + 6'd1;
            lenb_in   = lenb_ff + 3'd1;
            if (lenb_ff == LEN_LAST) begin
               cmd.start = 1'b1;
               round_in  = '0;
               state_in  = S_ROUND;
               ret_in    = RET_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_tready) begin
               if (word_ff == WORD_LAST) begin
                  cmd.clear = 1'b1;
                  word_in   = '0;
                  state_in  = S_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_IDLE;
         pos_ff   <= '0;
         round_ff <= '0;
         lenb_ff  <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pos_ff   <= pos_in;
         round_ff <= round_in;
         lenb_ff  <= lenb_in;
         word_ff  <= word_in;
      end
   end

   // input and result sides never open together
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result channels open at once");

   // the eightieth round hands over to the fold
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && round_ff == ROUND_LAST) |=> (state_ff == S_FOLD))
      else $error("compression did not end after round 79");

   // length trailer starts on byte 56 of the block
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PADLEN && lenb_ff == 3'd0) |-> (pos_ff == 6'd56))
      else $error("length trailer misplaced");

   // digest goes out only on a block boundary
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pos_ff == 6'd0))
      else $error("digest emitted mid block");

   // digest always begins with the most significant word
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (word_index == 3'd0))
      else $error("digest did not start at word 0");

endmodule

`default_nettype wire

@@ hdl/sha1_message_hasher.sv @@
// ----------------------------------------------------------------------------
// sha1_message_hasher
// byte-stream sha-1 hasher with padding and five-word digest output
// ----------------------------------------------------------------------------
// req channel: one item per message byte; req_tuser marks whether req_tdata
//   carries a byte, req_tlast ends the message (after the byte, if any). an
//   item with neither is taken and ignored; an end-only item with no earlier
//   bytes yields the digest of the empty message.
// rsp channel: five items per message, digest word 0 (most significant)
//   first; rsp_tuser gives the word position, rsp_tlast flags word 4.
// timing: byte items are taken while req_tready is high. the 64th byte of a
//   block starts the compression, 80 rounds at one per cycle on a single
//   round unit and then a fold into the chaining values; req_tready stays
//   low throughout, so no byte is taken until the block is done.
// at message end (after the compression of a block completed by the last
//   byte, if any) the padding bytes are shifted in one per cycle: 0x80, zeros
//   and the 8-byte bit length, which spills into a second block when it does
//   not fit in the first. each padded block takes a further compression, then
//   the digest words appear.
// the block works on one message end at a time: req_tready is low while the
//   digest is offered, and a stalled receiver simply holds the current word
//   until rsp_tready rises. after word 4 the chaining values and the length
//   counter go back to their initial values and input reopens.
// reset (synchronous, active high) leaves the block idle and ready for the
//   first byte of a new message.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_hasher import sha1mh_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] has_byte
   input  wire logic        req_tlast,   // end_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] digest_word
   output logic [2:0]       rsp_tuser,   // [2:0] word_index
   output logic             rsp_tlast    // last_word
);

   dp_cmd_type cmd;

   // controller: byte position, padding, round count and output sequence
   sha1mh_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_has_byte (req_tuser),
      .req_end      (req_tlast),
      .rsp_tready   (rsp_tready),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .word_index   (rsp_tuser),
      .last_word    (rsp_tlast),
      .cmd          (cmd)
   );

   // datapath: block buffer, schedule, round unit and chaining values
   sha1mh_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_byte    (req_tdata),
      .digest_word (rsp_tdata)
   );

endmodule

`default_nettype wire
